// ----- hw/rtl/pslt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pslt_pkg: shared types and constants of the sequence loss tracker
// Table geometry, field widths, entry layout, FSM states and register codes.
// ----------------------------------------------------------------------------
package pslt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Field widths
  localparam int SRC_W     = 16;
  localparam int SEQ_W     = 16;
  localparam int CNT_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_IDX_W = 5;

  // Register reset values
  localparam logic [CFG_W-1:0] RESTART_MIN_RCVD_RST   = CFG_W'(10);
  localparam logic [CFG_W-1:0] RESTART_SEQ_BELOW_RST  = CFG_W'(3);
  localparam logic [CFG_W-1:0] RESTART_LAST_ABOVE_RST = CFG_W'(100);

  typedef logic [SRC_W-1:0] src_t;
  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESTART_MIN_RCVD   = CFG_IDX_W'(0),
    CFG_RESTART_SEQ_BELOW  = CFG_IDX_W'(1),
    CFG_RESTART_LAST_ABOVE = CFG_IDX_W'(2)
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_UPDATE
  } state_t;

  // One table entry's statistics
  typedef struct packed {
    seq_t first;
    seq_t last;
    cnt_t received;
    cnt_t gaps;
    cnt_t dups;
  } entry_t;

  // Restart rule thresholds
  typedef struct packed {
    cnt_t min_received;
    seq_t seq_below;
    seq_t last_above;
  } restart_cfg_t;

  // Result of comparing one tag slot against the key
  typedef struct packed {
    logic vld;
    logic hit;
    logic free;
    idx_t idx;
  } tag_probe_t;

  // Updated entry plus restart flag
  typedef struct packed {
    logic   restarted;
    entry_t entry;
  } upd_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pslt_tags.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pslt_tags: source-id tag store and shared tag comparator
// One slot is read per cycle; the registered tag is compared to the key.
// ----------------------------------------------------------------------------
module pslt_tags
  import pslt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       rd_en,
  input  wire idx_t       rd_addr,
  input  wire src_t       key,
  input  wire logic       wr_en,
  input  wire idx_t       wr_addr,
  input  wire src_t       wr_src,
  output tag_probe_t      probe
);

  src_t                     src_mem [TABLE_ENTRIES];
  src_t                     rd_src_r;
  idx_t                     rd_idx_r;
  logic                     rd_vld_r;
  logic [TABLE_ENTRIES-1:0] used_r;

  // Tag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      src_mem[wr_addr] <= wr_src;
    end
    rd_src_r <= src_mem[rd_addr];
    rd_idx_r <= rd_addr;
  end

  // Slot-used bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (wr_en) begin
        used_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Shared comparator on the slot read last cycle
  always_comb begin
    probe.vld  = rd_vld_r;
    probe.hit  = used_r[rd_idx_r] && (rd_src_r == key);
    probe.free = !used_r[rd_idx_r];
    probe.idx  = rd_idx_r;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pslt_stats.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pslt_stats: per-slot statistics memory and update datapath
// Reads the chosen slot, applies the sequence rules, writes the slot back.
// ----------------------------------------------------------------------------
module pslt_stats
  import pslt_pkg::*;
(
  input  wire logic         clk,
  input  wire idx_t         addr,
  input  wire logic         wr_en,
  input  wire logic         fresh,
  input  wire seq_t         seq,
  input  wire restart_cfg_t cfg,
  output upd_result_t       result
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q_r;

  seq_t   next_seq;
  seq_t   skipped;
  logic   restart;

  // Statistics memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= result.entry;
    end
    rd_q_r <= mem[addr];
  end

  // Sequence rules
  always_comb begin
    next_seq = SEQ_W'(rd_q_r.last + SEQ_W'(1));
    skipped  = SEQ_W'(seq - rd_q_r.last - SEQ_W'(1));
    restart  = !fresh && (rd_q_r.received > cfg.min_received) &&
               (seq < cfg.seq_below) && (rd_q_r.last > cfg.last_above);

    result.restarted = restart;
    result.entry     = rd_q_r;
    if (fresh || restart) begin
      result.entry.first    = seq;
      result.entry.last     = seq;
      result.entry.received = CNT_W'(1);
      result.entry.gaps     = '0;
      result.entry.dups     = '0;
    end else if (seq == next_seq) begin
      result.entry.received = CNT_W'(rd_q_r.received + CNT_W'(1));
      result.entry.last     = seq;
    end else if (seq > next_seq) begin
      // jump ahead: skipped numbers go to the gap count
      result.entry.gaps     = CNT_W'(rd_q_r.gaps + skipped);
      result.entry.received = CNT_W'(rd_q_r.received + CNT_W'(1));
      result.entry.last     = seq;
    end else begin
      result.entry.dups     = CNT_W'(rd_q_r.dups + CNT_W'(1));
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/per_source_sequence_loss_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_sequence_loss_tracker: per-source packet loss accounting
//
// One transaction per received packet: pulse start with the source id bytes
// and sequence number while busy is low. The block scans its slot table for
// the source (one slot compared per cycle on the shared tag comparator),
// claims the lowest free slot for a new source, updates the slot's first/last
// sequence and received, gap and duplicate counts, and reports the result on
// out_* for exactly one cycle marked by out_valid. A full table gives a
// result with every field zero and changes nothing.
// Busy spans the tag scan and the update; the scan stops at a hit and covers
// every slot for a new source or a full table. out_valid rises in the same
// cycle that busy falls, and a new start is taken in that same cycle. The
// receiver cannot stall the result. Configuration writes (cfg_we, cfg_index,
// cfg_wdata) take effect at once; the user must make them only while busy is
// low, and the block does not enforce this. Reset clears all slots and loads
// the restart thresholds to 10, 3 and 100; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_source_sequence_loss_tracker
  import pslt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // packet input
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [BYTE_W-1:0]    in_source_high,
  input  wire logic [BYTE_W-1:0]    in_source_low,
  input  wire logic [SEQ_W-1:0]     in_seq_num,
  // result output
  output logic                      out_valid,
  output logic                      out_accepted,
  output logic [OUT_IDX_W-1:0]      out_entry_index,
  output logic                      out_new_entry,
  output logic                      out_restarted,
  output logic [SEQ_W-1:0]          out_first_seq,
  output logic [SEQ_W-1:0]          out_last_seq,
  output logic [CNT_W-1:0]          out_received_total,
  output logic [CNT_W-1:0]          out_gap_total,
  output logic [CNT_W-1:0]          out_dup_total,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  state_t       state_r, state_nxt;
  src_t         src_r, src_nxt;
  seq_t         seq_r, seq_nxt;
  idx_t         scan_r, scan_nxt;
  logic         issue_done_r, issue_done_nxt;
  logic         free_vld_r, free_vld_nxt;
  idx_t         free_idx_r, free_idx_nxt;
  idx_t         slot_r, slot_nxt;
  logic         fresh_r, fresh_nxt;
  logic         full_r, full_nxt;
  restart_cfg_t cfg_r;

  logic         out_valid_r, out_valid_nxt;
  logic         out_accepted_r, out_accepted_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic         out_new_r, out_new_nxt;
  logic         out_restart_r, out_restart_nxt;
  entry_t       out_entry_r, out_entry_nxt;

  logic         rd_en;
  logic         stats_wr;
  logic         tag_wr;
  tag_probe_t   probe;
  upd_result_t  upd;

  // Tag store with shared comparator
  pslt_tags u_tags (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (scan_r),
    .key     (src_r),
    .wr_en   (tag_wr),
    .wr_addr (slot_r),
    .wr_src  (src_r),
    .probe   (probe)
  );

  // Statistics memory and update
  pslt_stats u_stats (
    .clk    (clk),
    .addr   (slot_r),
    .wr_en  (stats_wr),
    .fresh  (fresh_r),
    .seq    (seq_r),
    .cfg    (cfg_r),
    .result (upd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_received <= RESTART_MIN_RCVD_RST;
      cfg_r.seq_below    <= RESTART_SEQ_BELOW_RST;
      cfg_r.last_above   <= RESTART_LAST_ABOVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESTART_MIN_RCVD:   cfg_r.min_received <= cfg_wdata;
        CFG_RESTART_SEQ_BELOW:  cfg_r.seq_below    <= cfg_wdata;
        CFG_RESTART_LAST_ABOVE: cfg_r.last_above   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Transaction payload and scan bookkeeping
  always_ff @(posedge clk) begin
    src_r          <= src_nxt;
    seq_r          <= seq_nxt;
    scan_r         <= scan_nxt;
    issue_done_r   <= issue_done_nxt;
    free_vld_r     <= free_vld_nxt;
    free_idx_r     <= free_idx_nxt;
    slot_r         <= slot_nxt;
    fresh_r        <= fresh_nxt;
    full_r         <= full_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_idx_r      <= out_idx_nxt;
    out_new_r      <= out_new_nxt;
    out_restart_r  <= out_restart_nxt;
    out_entry_r    <= out_entry_nxt;
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt        = state_r;
    src_nxt          = src_r;
    seq_nxt          = seq_r;
    scan_nxt         = scan_r;
    issue_done_nxt   = issue_done_r;
    free_vld_nxt     = free_vld_r;
    free_idx_nxt     = free_idx_r;
    slot_nxt         = slot_r;
    fresh_nxt        = fresh_r;
    full_nxt         = full_r;
    out_valid_nxt    = 1'b0;
    out_accepted_nxt = out_accepted_r;
    out_idx_nxt      = out_idx_r;
    out_new_nxt      = out_new_r;
    out_restart_nxt  = out_restart_r;
    out_entry_nxt    = out_entry_r;
    rd_en            = 1'b0;
    stats_wr         = 1'b0;
    tag_wr           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          src_nxt        = {in_source_high, in_source_low};
          seq_nxt        = in_seq_num;
          scan_nxt       = '0;
          issue_done_nxt = 1'b0;
          free_vld_nxt   = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one tag read per cycle
        rd_en = !issue_done_r;
        if (rd_en) begin
          scan_nxt       = IDX_W'(scan_r + IDX_W'(1));
          issue_done_nxt = (scan_r == LAST_IDX);
        end
        // examine the slot read last cycle
        if (probe.vld) begin
          if (probe.hit) begin
            slot_nxt  = probe.idx;
            fresh_nxt = 1'b0;
            full_nxt  = 1'b0;
            state_nxt = ST_READ;
          end else begin
            if (probe.free && !free_vld_r) begin
              free_vld_nxt = 1'b1;
              free_idx_nxt = probe.idx;
            end
            if (probe.idx == LAST_IDX) begin
              // source not present: claim lowest free slot, or table full
              fresh_nxt = 1'b1;
              full_nxt  = !(free_vld_r || probe.free);
              slot_nxt  = free_vld_r ? free_idx_r : probe.idx;
              state_nxt = ST_UPDATE;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        stats_wr      = !full_r;
        tag_wr        = fresh_r && !full_r;
        out_valid_nxt = 1'b1;
        if (full_r) begin
          out_accepted_nxt = 1'b0;
          out_idx_nxt      = '0;
          out_new_nxt      = 1'b0;
          out_restart_nxt  = 1'b0;
          out_entry_nxt    = '0;
        end else begin
          out_accepted_nxt = 1'b1;
          out_idx_nxt      = OUT_IDX_W'(slot_r);
          out_new_nxt      = fresh_r;
          out_restart_nxt  = upd.restarted;
          out_entry_nxt    = upd.entry;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Ports
  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_accepted       = out_accepted_r;
  assign out_entry_index    = out_idx_r;
  assign out_new_entry      = out_new_r;
  assign out_restarted      = out_restart_r;
  assign out_first_seq      = out_entry_r.first;
  assign out_last_seq       = out_entry_r.last;
  assign out_received_total = out_entry_r.received;
  assign out_gap_total      = out_entry_r.gaps;
  assign out_dup_total      = out_entry_r.dups;

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a transaction is in progress");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |->
      (out_entry_index == '0 && !out_new_entry && out_received_total == '0))
    else $error("dropped packet result not all zero");

  a_restart_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_restarted) |->
      (!out_new_entry && out_received_total == CNT_W'(1) &&
       out_first_seq == out_last_seq))
    else $error("restart result inconsistent");

endmodule
`default_nettype wire
